@@ rtl/core/lqwd_pkg.sv @@
// Package for the largest-queue work dispatcher: codes, default sizes and the
// structs shared between the stream cells and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lqwd_pkg;

  localparam int NUM_STREAMS_DEF = 16;
  localparam int NUM_DEVICES_DEF = 4;
  localparam int COUNT_BITS_DEF  = 16;

  // Widest index and count that any legal parameter setting needs.
  localparam int IDX_MAX_BITS = 8;
  localparam int CNT_MAX_BITS = 32;

  localparam logic [4:0] STREAMS_IN_USE_RST = 5'd16;

  localparam logic KIND_UPDATE  = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic [1:0] OUTCOME_ASSIGN   = 2'd0;
  localparam logic [1:0] OUTCOME_RETRY    = 2'd1;
  localparam logic [1:0] OUTCOME_SHUTDOWN = 2'd2;

  // Running result of a scan, handed from one stream cell to the next.
  typedef struct packed {
    logic                    valid;
    logic                    found;
    logic                    any_busy;
    logic [CNT_MAX_BITS-1:0] best_count;
    logic [IDX_MAX_BITS-1:0] best_idx;
  } scan_t;

  // Commands broadcast from the controller to every stream cell.
  typedef struct packed {
    logic                    wr_en;
    logic [IDX_MAX_BITS-1:0] wr_idx;
    logic [CNT_MAX_BITS-1:0] wr_cnt;
    logic                    clr_en;
    logic [IDX_MAX_BITS-1:0] clr_idx;
    logic                    set_en;
    logic [IDX_MAX_BITS-1:0] set_idx;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/lqwd_ifs.sv @@
// Channel interfaces of the largest-queue work dispatcher: request input,
// result output and configuration write. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lqwd_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  stream_index;
  logic [15:0] queued_count;
  logic [1:0]  device_index;

  modport source (output valid, kind, stream_index, queued_count, device_index,
                  input ready);
  modport sink (input valid, kind, stream_index, queued_count, device_index,
                output ready);
endinterface

interface lqwd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] target_device;
  logic [1:0] outcome;
  logic [3:0] assigned_stream;
  logic       last_result;

  modport source (output valid, target_device, outcome, assigned_stream, last_result,
                  input ready);
  modport sink (input valid, target_device, outcome, assigned_stream, last_result,
                output ready);
endinterface

interface lqwd_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lqwd_cell.sv @@
// One stream cell: holds a stream's queued count and busy flag and folds
// itself into the scan result passing by. Depends on lqwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lqwd_cell #(
  parameter int IDX        = 0,
  parameter int COUNT_BITS = lqwd_pkg::COUNT_BITS_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire logic [4:0]           streams_in_use,
  input  wire lqwd_pkg::cell_ctl_t  ctl,
  input  wire lqwd_pkg::scan_t      scan_in,
  output lqwd_pkg::scan_t           scan_out
);

  localparam logic [lqwd_pkg::IDX_MAX_BITS-1:0] IdxSel = lqwd_pkg::IDX_MAX_BITS'(IDX);
  localparam logic [8:0]                        IdxNum = 9'(IDX);

  logic [COUNT_BITS-1:0] count_r;
  logic                  busy_r;
  lqwd_pkg::scan_t       scan_r;
  lqwd_pkg::scan_t       scan_nxt;
  logic [lqwd_pkg::CNT_MAX_BITS-1:0] count_ext;
  logic                  better;

  assign count_ext = lqwd_pkg::CNT_MAX_BITS'(count_r);
  // Strict compare keeps the lowest index on ties, since lower cells go first.
  assign better = (IdxNum < 9'(streams_in_use)) && !busy_r &&
                  (count_ext > scan_in.best_count);

  always_comb begin
    scan_nxt          = scan_in;
    scan_nxt.any_busy = scan_in.any_busy | busy_r;
    if (better) begin
      scan_nxt.found      = 1'b1;
      scan_nxt.best_count = count_ext;
      scan_nxt.best_idx   = IdxSel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      busy_r       <= 1'b0;
      scan_r.valid <= 1'b0;
    end else begin
      if (ctl.wr_en && (ctl.wr_idx == IdxSel)) begin
        count_r <= ctl.wr_cnt[COUNT_BITS-1:0];
      end
      if (ctl.set_en && (ctl.set_idx == IdxSel)) begin
        busy_r <= 1'b1;
      end else if (ctl.clr_en && (ctl.clr_idx == IdxSel)) begin
        busy_r <= 1'b0;
      end
      scan_r.valid <= scan_in.valid;
    end
    scan_r.found      <= scan_nxt.found;
    scan_r.any_busy   <= scan_nxt.any_busy;
    scan_r.best_count <= scan_nxt.best_count;
    scan_r.best_idx   <= scan_nxt.best_idx;
  end

  assign scan_out = scan_r;

endmodule

`default_nettype wire

@@ rtl/core/largest_queue_work_dispatcher.sv @@
// Top level of the largest-queue work dispatcher: controller, device table
// and the chain of stream cells. Depends on lqwd_pkg, lqwd_ifs and lqwd_cell.
// Update transaction: produces no result.
// Request transaction: the scan walks the chain one cell per cycle, and the
// result follows once the scan leaves the last cell; a shutdown then
// delivers NUM_DEVICES results, one per output transaction. A new transaction is
// taken only after the last result is accepted and the controller is idle again.
// Synchronous active-low reset clears counts, busy flags, hold-valid flags; default count width is 16.
`timescale 1ns / 1ps
`default_nettype none

module largest_queue_work_dispatcher #(
  parameter int NUM_STREAMS = lqwd_pkg::NUM_STREAMS_DEF,
  parameter int NUM_DEVICES = lqwd_pkg::NUM_DEVICES_DEF,
  parameter int COUNT_BITS  = lqwd_pkg::COUNT_BITS_DEF
) (
  input wire clk,
  input wire rst_n,
  lqwd_in_if.sink     in_ch,
  lqwd_out_if.source  out_ch,
  lqwd_cfg_if.sink    cfg_ch
);

  localparam int IW = $clog2(NUM_STREAMS);
  localparam int DW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam logic [DW-1:0] LastDev = DW'(NUM_DEVICES - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESULT, S_SHUT} state_t;

  state_t                state_r;
  logic [4:0]            streams_in_use_r;
  logic                  start_r;
  logic [DW-1:0]         dev_r;
  logic [DW-1:0]         sd_cnt_r;
  logic [IW-1:0]         holds_r [NUM_DEVICES];
  logic [NUM_DEVICES-1:0] hv_r;

  logic                  out_valid_r;
  logic [1:0]            target_r;
  logic [1:0]            outcome_r;
  logic [3:0]            stream_r;
  logic                  last_r;

  lqwd_pkg::scan_t       chain [NUM_STREAMS+1];
  lqwd_pkg::cell_ctl_t   ctl;

  logic                  in_acc;
  logic                  req_ok;
  logic [DW-1:0]         dsel;
  logic [31:0]           qc_ext;
  logic [7:0]            sd_ext;
  lqwd_pkg::scan_t       res;

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign req_ok = in_acc && (in_ch.kind == lqwd_pkg::KIND_REQUEST) &&
                  (32'(in_ch.device_index) < NUM_DEVICES);
  assign dsel   = DW'(in_ch.device_index);
  assign qc_ext = 32'(in_ch.queued_count);
  assign sd_ext = 8'(sd_cnt_r);
  assign res    = chain[NUM_STREAMS];

  always_comb begin
    ctl.wr_en   = in_acc && (in_ch.kind == lqwd_pkg::KIND_UPDATE);
    ctl.wr_idx  = lqwd_pkg::IDX_MAX_BITS'(in_ch.stream_index);
    ctl.wr_cnt  = lqwd_pkg::CNT_MAX_BITS'(qc_ext[COUNT_BITS-1:0]);
    ctl.clr_en  = req_ok && hv_r[dsel];
    ctl.clr_idx = lqwd_pkg::IDX_MAX_BITS'(holds_r[dsel]);
    ctl.set_en  = (state_r == S_SCAN) && res.valid && res.found;
    ctl.set_idx = res.best_idx;
  end

  // The scan enters the chain in the cycle after the request is accepted, once the released
  // stream is already idle.
  always_comb begin
    chain[0]            = '0;
    chain[0].valid      = start_r;
  end

  for (genvar i = 0; i < NUM_STREAMS; i++) begin : g_cell
    lqwd_cell #(
      .IDX        (i),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .streams_in_use (streams_in_use_r),
      .ctl            (ctl),
      .scan_in        (chain[i]),
      .scan_out       (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      streams_in_use_r <= lqwd_pkg::STREAMS_IN_USE_RST;
      start_r          <= 1'b0;
      hv_r             <= '0;
      out_valid_r      <= 1'b0;
      sd_cnt_r         <= '0;
    end else begin
      start_r <= 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        streams_in_use_r <= cfg_ch.data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (req_ok) begin
            hv_r[dsel] <= 1'b0;
            dev_r      <= dsel;
            start_r    <= 1'b1;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (res.valid) begin
            out_valid_r <= 1'b1;
            priority if (res.found) begin
              holds_r[dev_r] <= res.best_idx[IW-1:0];
              hv_r[dev_r]    <= 1'b1;
              target_r       <= 2'(dev_r);
              outcome_r      <= lqwd_pkg::OUTCOME_ASSIGN;
              stream_r       <= res.best_idx[3:0];
              last_r         <= 1'b1;
              state_r        <= S_RESULT;
            end else if (res.any_busy) begin
              target_r  <= 2'(dev_r);
              outcome_r <= lqwd_pkg::OUTCOME_RETRY;
              stream_r  <= '0;
              last_r    <= 1'b1;
              state_r   <= S_RESULT;
            end else begin
              sd_cnt_r  <= '0;
              target_r  <= '0;
              outcome_r <= lqwd_pkg::OUTCOME_SHUTDOWN;
              stream_r  <= '0;
              last_r    <= (LastDev == '0);
              state_r   <= S_SHUT;
            end
          end
        end
        S_RESULT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_SHUT: begin
          if (out_ch.ready) begin
            if (sd_cnt_r == LastDev) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              sd_cnt_r <= sd_cnt_r + 1'b1;
              last_r   <= ((sd_cnt_r + 1'b1) == LastDev);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.target_device   = (state_r == S_SHUT) ? sd_ext[1:0] : target_r;
  assign out_ch.outcome         = outcome_r;
  assign out_ch.assigned_stream = stream_r;
  assign out_ch.last_result     = last_r;

endmodule

`default_nettype wire
